### rtl/qgi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qgi_pkg
// Shared types, widths and the rotate step schedule of the quaternion gyro
// integrator.
// ----------------------------------------------------------------------------
package qgi_pkg;

  // Component width and derived datapath widths
  localparam int unsigned COMP_W    = 32;
  localparam int unsigned SUM_W     = COMP_W + 4;   // unnormalized component
  localparam int unsigned MAG_W     = COMP_W + 3;   // its magnitude
  localparam int unsigned PROD_W    = 2 * COMP_W;   // multiplier product
  localparam int unsigned SQ_W      = 2 * COMP_W;   // sum of squares
  localparam int unsigned CNT_W     = $clog2(COMP_W + 1);
  localparam int unsigned ROT_STEPS = 12;
  localparam int unsigned SQR_STEPS = 4;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam logic [COMP_W-1:0] ONE_Q = {2'b01, {(COMP_W-2){1'b0}}};

  // Request type codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ROTATE = 1'b1;

  // Component and angle indexes
  localparam logic [1:0] IDX_W = 2'd0;
  localparam logic [1:0] IDX_X = 2'd1;
  localparam logic [1:0] IDX_Y = 2'd2;
  localparam logic [1:0] IDX_Z = 2'd3;
  localparam logic [1:0] ANG_X = 2'd0;
  localparam logic [1:0] ANG_Y = 2'd1;
  localparam logic [1:0] ANG_Z = 2'd2;

  // Rotate schedule: product comp*angle, added to or subtracted from dest
  localparam logic [1:0] ROT_COMP [ROT_STEPS] = '{
    IDX_X, IDX_Y, IDX_Z,
    IDX_W, IDX_Y, IDX_Z,
    IDX_W, IDX_X, IDX_Z,
    IDX_W, IDX_X, IDX_Y};
  localparam logic [1:0] ROT_ANG [ROT_STEPS] = '{
    ANG_X, ANG_Y, ANG_Z,
    ANG_X, ANG_Z, ANG_Y,
    ANG_Y, ANG_Z, ANG_X,
    ANG_Z, ANG_Y, ANG_X};
  localparam logic [1:0] ROT_DEST [ROT_STEPS] = '{
    IDX_W, IDX_W, IDX_W,
    IDX_X, IDX_X, IDX_X,
    IDX_Y, IDX_Y, IDX_Y,
    IDX_Z, IDX_Z, IDX_Z};
  localparam logic ROT_SUB [ROT_STEPS] = '{
    1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic  req_type;
    comp_t load_w;
    comp_t load_x;
    comp_t load_y;
    comp_t load_z;
    comp_t angle_x;
    comp_t angle_y;
    comp_t angle_z;
  } qgi_req_t;

  typedef struct packed {
    comp_t out_w;
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    logic  zero_norm;
  } qgi_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MDRAIN,
    ST_ABS,
    ST_SHIFT,
    ST_SQR,
    ST_SDRAIN,
    ST_INIT,
    ST_SQRT,
    ST_DIV,
    ST_FINISH
  } qgi_state_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_ROT,
    MUL_SQR
  } qgi_mul_e;

  typedef struct packed {
    logic       accept;
    qgi_mul_e   mul_op;
    logic [3:0] step;
    logic       abs_en;
    logic       shift_en;
    logic       init_en;
    logic       sqrt_en;
    logic       div_en;
    logic       finish;
  } qgi_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic shift_done;
  } qgi_sts_t;

endpackage
`default_nettype wire

### rtl/qgi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qgi_ctrl
// Sequencer: steps the shared multiplier, normalize shift, square root and
// divider lanes, and holds the result valid flag.
// ----------------------------------------------------------------------------
module qgi_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               req_type_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  input  qgi_pkg::qgi_sts_t sts_i,
  output qgi_pkg::qgi_cmd_t cmd_o
);
  import qgi_pkg::*;

  qgi_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CNT_W'(1);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = (req_type_i == REQ_ROTATE) ? ST_MUL : ST_ABS;
        end
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(ROT_STEPS - 1)) begin
          state_d = ST_MDRAIN;
        end
      end
      ST_MDRAIN: state_d = ST_ABS;
      ST_ABS:    state_d = ST_SHIFT;
      ST_SHIFT: begin
        cnt_d = '0;
        if (sts_i.mag_zero) begin
          state_d = ST_FINISH;
        end else if (sts_i.shift_done) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (cnt_q == CNT_W'(SQR_STEPS - 1)) begin
          state_d = ST_SDRAIN;
        end
      end
      ST_SDRAIN: state_d = ST_INIT;
      ST_INIT: begin
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_q == CNT_W'(COMP_W - 1)) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(COMP_W - 2)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.step = cnt_q[3:0];
    unique case (state_q)
      ST_IDLE:   cmd_o.accept   = in_valid_i;
      ST_MUL:    cmd_o.mul_op   = MUL_ROT;
      ST_ABS:    cmd_o.abs_en   = 1'b1;
      ST_SHIFT:  cmd_o.shift_en = 1'b1;
      ST_SQR:    cmd_o.mul_op   = MUL_SQR;
      ST_INIT:   cmd_o.init_en  = 1'b1;
      ST_SQRT:   cmd_o.sqrt_en  = 1'b1;
      ST_DIV:    cmd_o.div_en   = 1'b1;
      ST_FINISH: cmd_o.finish   = !out_busy;
      default:   cmd_o.mul_op   = MUL_NONE;
    endcase
  end

  // Result valid: set on finish, cleared when the item is taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### rtl/qgi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qgi_dp
// Datapath: attitude registers, shared multiplier with accumulate, normalize
// shifter, bit-serial square root and four restoring divider lanes.
// ----------------------------------------------------------------------------
module qgi_dp (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  qgi_pkg::qgi_req_t in_data_i,
  input  qgi_pkg::qgi_cmd_t cmd_i,
  output qgi_pkg::qgi_sts_t sts_o,
  output qgi_pkg::qgi_rsp_t out_data_o
);
  import qgi_pkg::*;

  comp_t                    att_q [4];
  comp_t                    ang_q [3];
  logic signed [SUM_W-1:0]  s_q   [4];
  logic [MAG_W-1:0]         mag_q [4];
  logic                     neg_q [4];
  logic signed [PROD_W-1:0] prod_q;
  qgi_mul_e                 pk_q;
  logic [3:0]               pi_q;
  logic [SQ_W-1:0]          sum_q, v_q, res_q, bit_q;
  logic [COMP_W:0]          rem_q [4];
  logic [COMP_W-2:0]        quo_q [4];
  qgi_rsp_t                 out_q;

  comp_t                    opa, opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  term;
  logic [MAG_W-1:0]         orv;
  logic                     mag_hi, mag_lo;
  logic [SQ_W-1:0]          trial;
  logic [COMP_W:0]          n_ext;
  comp_t                    quo_s [4];

  // Multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_op)
      MUL_ROT: begin
        opa = att_q[ROT_COMP[cmd_i.step]];
        opb = ang_q[ROT_ANG[cmd_i.step]];
      end
      MUL_SQR: begin
        opa = {1'b0, mag_q[cmd_i.step[1:0]][COMP_W-2:0]};
        opb = opa;
      end
      default: opa = '0;
    endcase
  end

  assign prod    = opa * opb;
  assign prod_sh = prod_q >>> (COMP_W - 3);
  assign term    = prod_sh[SUM_W-1:0];

  // Normalize shift status
  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      orv = orv | mag_q[i];
    end
  end
  assign mag_hi           = |orv[MAG_W-1:COMP_W-1];
  assign mag_lo           = ~|orv[MAG_W-1:COMP_W-2];
  assign sts_o.mag_zero   = (orv == '0);
  assign sts_o.shift_done = !mag_hi && !mag_lo;

  assign trial = res_q + bit_q;
  assign n_ext = {1'b0, res_q[COMP_W-1:0]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quo_s[i] = {1'b0, quo_q[i]};
    end
  end

  // Product pipeline register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_q <= MUL_NONE;
    end else begin
      pk_q <= cmd_i.mul_op;
    end
  end

  // Attitude state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q[0] <= ONE_Q;
      att_q[1] <= '0;
      att_q[2] <= '0;
      att_q[3] <= '0;
    end else if (cmd_i.finish) begin
      for (int i = 0; i < 4; i++) begin
        if (sts_o.mag_zero) begin
          att_q[i] <= (i == 0) ? comp_t'(ONE_Q) : comp_t'(0);
        end else begin
          att_q[i] <= neg_q[i] ? -quo_s[i] : quo_s[i];
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    pi_q   <= cmd_i.step;

    // Take an item
    if (cmd_i.accept) begin
      ang_q[0] <= in_data_i.angle_x;
      ang_q[1] <= in_data_i.angle_y;
      ang_q[2] <= in_data_i.angle_z;
      if (in_data_i.req_type == REQ_LOAD) begin
        s_q[0] <= SUM_W'(in_data_i.load_w);
        s_q[1] <= SUM_W'(in_data_i.load_x);
        s_q[2] <= SUM_W'(in_data_i.load_y);
        s_q[3] <= SUM_W'(in_data_i.load_z);
      end else begin
        for (int i = 0; i < 4; i++) begin
          s_q[i] <= SUM_W'(att_q[i]);
        end
      end
    end

    // Accumulate the previous product
    if (pk_q == MUL_ROT) begin
      if (ROT_SUB[pi_q]) begin
        s_q[ROT_DEST[pi_q]] <= s_q[ROT_DEST[pi_q]] - term;
      end else begin
        s_q[ROT_DEST[pi_q]] <= s_q[ROT_DEST[pi_q]] + term;
      end
    end else if (pk_q == MUL_SQR) begin
      sum_q <= sum_q + prod_q[SQ_W-1:0];
    end

    // Signs and magnitudes
    if (cmd_i.abs_en) begin
      sum_q <= '0;
      for (int i = 0; i < 4; i++) begin
        neg_q[i] <= s_q[i][SUM_W-1];
        mag_q[i] <= s_q[i][SUM_W-1] ? MAG_W'(-s_q[i]) : MAG_W'(s_q[i]);
      end
    end

    // Bring the largest magnitude into [1.0, 2.0)
    if (cmd_i.shift_en) begin
      for (int i = 0; i < 4; i++) begin
        if (mag_hi) begin
          mag_q[i] <= mag_q[i] >> 1;
        end else if (mag_lo) begin
          mag_q[i] <= mag_q[i] << 1;
        end
      end
    end

    // Root and divider setup
    if (cmd_i.init_en) begin
      v_q   <= sum_q;
      res_q <= '0;
      bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
      for (int i = 0; i < 4; i++) begin
        rem_q[i] <= {2'b00, mag_q[i][COMP_W-2:0]};
        quo_q[i] <= '0;
      end
    end

    // One root bit per cycle
    if (cmd_i.sqrt_en) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    // One quotient bit per cycle in each lane
    if (cmd_i.div_en) begin
      for (int i = 0; i < 4; i++) begin
        if (rem_q[i] >= n_ext) begin
          rem_q[i] <= (rem_q[i] - n_ext) << 1;
          quo_q[i] <= {quo_q[i][COMP_W-3:0], 1'b1};
        end else begin
          rem_q[i] <= rem_q[i] << 1;
          quo_q[i] <= {quo_q[i][COMP_W-3:0], 1'b0};
        end
      end
    end

    // Result register
    if (cmd_i.finish) begin
      out_q.zero_norm <= sts_o.mag_zero;
      if (sts_o.mag_zero) begin
        out_q.out_w <= ONE_Q;
        out_q.out_x <= '0;
        out_q.out_y <= '0;
        out_q.out_z <= '0;
      end else begin
        out_q.out_w <= neg_q[0] ? -quo_s[0] : quo_s[0];
        out_q.out_x <= neg_q[1] ? -quo_s[1] : quo_s[1];
        out_q.out_y <= neg_q[2] ? -quo_s[2] : quo_s[2];
        out_q.out_z <= neg_q[3] ? -quo_s[3] : quo_s[3];
      end
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

### rtl/quaternion_gyro_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator
// Attitude quaternion with first-order gyro integration and normalization.
// ----------------------------------------------------------------------------
// Holds one Q2.30 attitude quaternion, identity after reset. A load item
// replaces it, a rotate item adds half-angle derivative terms (angles Q4.28);
// either way the result is normalized, stored and returned as one item. An
// all-zero quaternion falls back to identity with zero_norm set. One item is
// in work at a time. Its time is set by the 12 shared multiplies of a rotate,
// up to 30 normalize shifts, the sum of squares, the bit-serial square root
// and the divider with its 31 quotient bits. A zero norm item skips the sum
// of squares, root and divider. A new item is taken while the last result waits.
module quaternion_gyro_integrator (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  qgi_pkg::qgi_req_t in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output qgi_pkg::qgi_rsp_t out_data_o
);
  import qgi_pkg::*;

  qgi_cmd_t cmd;
  qgi_sts_t sts;

  qgi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qgi_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
